// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes of the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_BIT    = 2'd0;
  localparam logic [1:0] CFG_START_STOP  = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_HOLD = 2'd2;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd3;

  // configuration reset values
  localparam logic [15:0] HALF_BIT_RST    = 16'd2;
  localparam logic [15:0] START_STOP_RST  = 16'd4;
  localparam logic [15:0] SAMPLE_HOLD_RST = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // sequencer phases
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_S1    = 5'd1;
  localparam logic [4:0] PH_S2    = 5'd2;
  localparam logic [4:0] PH_P1    = 5'd3;
  localparam logic [4:0] PH_P2    = 5'd4;
  localparam logic [4:0] PH_WLOW  = 5'd5;
  localparam logic [4:0] PH_WHIGH = 5'd6;
  localparam logic [4:0] PH_WGAP  = 5'd7;
  localparam logic [4:0] PH_AREL  = 5'd8;
  localparam logic [4:0] PH_AHIGH = 5'd9;
  localparam logic [4:0] PH_APOLL = 5'd10;
  localparam logic [4:0] PH_F1    = 5'd11;
  localparam logic [4:0] PH_F2    = 5'd12;
  localparam logic [4:0] PH_RLOW  = 5'd13;
  localparam logic [4:0] PH_RHIGH = 5'd14;
  localparam logic [4:0] PH_KLOW  = 5'd15;
  localparam logic [4:0] PH_KHIGH = 5'd16;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [15:0] start_stop_ticks;
    logic [15:0] sample_hold_ticks;
    logic [7:0]  ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } result_t;

endpackage

// ===== rtl/i2c_master_byte_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// i2c master byte engine: one timing tick per item, one result per tick
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------------
//  in       input      in_valid / in_stall  cmd_valid opcode tx_byte send_ack sda_in
//  out      output     out_valid/out_stall  scl sda released busy done rx ack_error
//  cfg      input      cfg_wr_en            cfg_index cfg_data
//
//  one item per cycle sustained while out_stall is low; an accepted item passes
//  the input register, then step logic into the result register
//  the rate is set by the loop through the sequencer state registers
//  reset: sequencer idle, both bus lines high, config at defaults
//  a stalled result holds the step stage; input stalls only when that stage is full
//
module i2c_master_byte_engine_top
  import i2cm_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_send_ack,
  input  logic        in_sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_released,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_ack_error,
  // configuration port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_r;
  result_t step_res;
  logic    res_valid_r;
  logic    advance;
  logic    in_take;

  // step stage moves when the result register is free or being drained
  assign advance  = !res_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks    <= HALF_BIT_RST;
      cfg_r.start_stop_ticks  <= START_STOP_RST;
      cfg_r.sample_hold_ticks <= SAMPLE_HOLD_RST;
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HALF_BIT:    cfg_r.half_bit_ticks    <= cfg_data;
        CFG_START_STOP:  cfg_r.start_stop_ticks  <= cfg_data;
        CFG_SAMPLE_HOLD: cfg_r.sample_hold_ticks <= cfg_data;
        CFG_ACK_TIMEOUT: cfg_r.ack_timeout_ticks <= cfg_data[7:0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd_valid <= in_cmd_valid;
      item_r.opcode    <= in_opcode;
      item_r.tx_byte   <= in_tx_byte;
      item_r.send_ack  <= in_send_ack;
      item_r.sda_in    <= in_sda_in;
    end
  end

  // sequencer: state advances once per item leaving the input register
  i2cm_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (item_valid_r && advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_scl_level    = res_r.scl_level;
  assign out_sda_level    = res_r.sda_level;
  assign out_sda_released = res_r.sda_released;
  assign out_busy_res     = res_r.busy_res;
  assign out_done_res     = res_r.done_res;
  assign out_rx_byte      = res_r.rx_byte;
  assign out_ack_error    = res_r.ack_error;

endmodule

// ===== rtl/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// bus sequencer state and one-tick step logic
// ----------------------------------------------------------------------------
module i2cm_core
  import i2cm_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int CW = COUNTER_WIDTH;
  localparam logic [32:0] CMAX = (33'h1 << CW) - 33'h1;

  logic [4:0]    phase_r, phase_nxt;
  logic [CW-1:0] tick_r, tick_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [7:0]    wait_r, wait_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic          ack_r, ack_nxt;
  logic          done, aerr;
  logic [7:0]    rx;
  logic [3:0]    bit_inc;
  logic [7:0]    shift_up;
  logic [CW-1:0] arm_half, arm_ss, arm_hold;

  // zero counts as one, large values clip to the counter range
  function automatic logic [CW-1:0] load_val(input logic [15:0] d);
    logic [32:0] v;
    v = {17'd0, d};
    if (v == 33'd0) v = 33'd1;
    if (v > CMAX) v = CMAX;
    return v[CW-1:0];
  endfunction

  assign arm_half = load_val(cfg.half_bit_ticks);
  assign arm_ss   = load_val(cfg.start_stop_ticks);
  assign arm_hold = load_val(cfg.sample_hold_ticks);
  assign bit_inc  = bit_r + 4'd1;
  assign shift_up = {shift_r[6:0], 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    aerr      = 1'b0;
    rx        = 8'd0;
    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid) begin
        unique case (item.opcode)
          OP_START: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1;
            phase_nxt = PH_S1; tick_nxt = arm_ss;
          end
          OP_STOP: begin
            scl_nxt = 1'b0; sda_nxt = 1'b0;
            phase_nxt = PH_P1; tick_nxt = arm_ss;
          end
          OP_WRITE: begin
            shift_nxt = item.tx_byte; bit_nxt = 4'd0;
            scl_nxt = 1'b0; sda_nxt = item.tx_byte[7];
            phase_nxt = PH_WLOW; tick_nxt = arm_half;
          end
          OP_READ: begin
            shift_nxt = 8'd0; bit_nxt = 4'd0; ack_nxt = item.send_ack;
            scl_nxt = 1'b0; sda_nxt = 1'b1;
            phase_nxt = PH_RLOW; tick_nxt = arm_half;
          end
        endcase
      end
    end else if (phase_r == PH_APOLL) begin
      // clock held high, polling for the slave ack
      if (!item.sda_in) begin
        scl_nxt = 1'b0; done = 1'b1; phase_nxt = PH_IDLE;
      end else if (wait_r >= cfg.ack_timeout_ticks) begin
        scl_nxt = 1'b0; sda_nxt = 1'b0;
        phase_nxt = PH_F1; tick_nxt = arm_ss;
      end else begin
        wait_nxt = wait_r + 8'd1;
      end
    end else if (tick_r > CW'(1)) begin
      tick_nxt = tick_r - CW'(1);
    end else begin
      unique case (phase_r)
        PH_S1: begin
          sda_nxt = 1'b0; phase_nxt = PH_S2; tick_nxt = arm_ss;
        end
        PH_S2: begin
          scl_nxt = 1'b0; done = 1'b1; phase_nxt = PH_IDLE;
        end
        PH_P1: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_P2; tick_nxt = arm_ss;
        end
        PH_P2: begin
          done = 1'b1; phase_nxt = PH_IDLE;
        end
        PH_WLOW: begin
          scl_nxt = 1'b1; phase_nxt = PH_WHIGH; tick_nxt = arm_half;
        end
        PH_WHIGH: begin
          scl_nxt = 1'b0; phase_nxt = PH_WGAP; tick_nxt = arm_half;
        end
        PH_WGAP: begin
          shift_nxt = shift_up;
          bit_nxt   = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            sda_nxt = 1'b1; phase_nxt = PH_AREL;
          end else begin
            sda_nxt = shift_up[7]; phase_nxt = PH_WLOW;
          end
          tick_nxt = arm_half;
        end
        PH_AREL: begin
          scl_nxt = 1'b1; phase_nxt = PH_AHIGH; tick_nxt = arm_half;
        end
        PH_AHIGH: begin
          wait_nxt = 8'd0; phase_nxt = PH_APOLL;
        end
        PH_F1: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_F2; tick_nxt = arm_ss;
        end
        PH_F2: begin
          done = 1'b1; aerr = 1'b1; phase_nxt = PH_IDLE;
        end
        PH_RLOW: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], item.sda_in};
          phase_nxt = PH_RHIGH; tick_nxt = arm_hold;
        end
        PH_RHIGH: begin
          bit_nxt = bit_inc;
          scl_nxt = 1'b0;
          if (bit_inc >= BITS_PER_BYTE) begin
            sda_nxt = !ack_r; phase_nxt = PH_KLOW;
          end else begin
            phase_nxt = PH_RLOW;
          end
          tick_nxt = arm_half;
        end
        PH_KLOW: begin
          scl_nxt = 1'b1; phase_nxt = PH_KHIGH; tick_nxt = arm_half;
        end
        PH_KHIGH: begin
          scl_nxt = 1'b0; done = 1'b1; rx = shift_r; phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      wait_r  <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
    end
  end

  always_comb begin
    result.scl_level    = scl_nxt;
    result.sda_level    = sda_nxt;
    result.sda_released = (phase_nxt == PH_AREL) || (phase_nxt == PH_AHIGH) ||
                          (phase_nxt == PH_APOLL) || (phase_nxt == PH_RLOW) ||
                          (phase_nxt == PH_RHIGH);
    result.busy_res     = (phase_nxt != PH_IDLE);
    result.done_res     = done;
    result.rx_byte      = rx;
    result.ack_error    = aerr;
  end

endmodule
